// ===== hdl/lrfe_pkg.sv =====
package lrfe_pkg;

   // input item: start an action or render one frame
   typedef struct packed {
      logic        opcode;
      logic [31:0] now_ticks;
   } req_type;

   // result item: one colour for one led, scaled by brightness when the envelope is active
   typedef struct packed {
      logic [3:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
      logic       finished;
   } rsp_type;

   // opcodes
   localparam logic OP_START  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_KIND = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAIN_COLOR  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_COLOR   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_STEP   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_TICKS  = 3'd5;

   // action kinds
   localparam logic [2:0] KIND_FADE   = 3'd0;
   localparam logic [2:0] KIND_GLOW   = 3'd1;
   localparam logic [2:0] KIND_THROB  = 3'd2;
   localparam logic [2:0] KIND_PULSAR = 3'd3;
   localparam logic [2:0] KIND_DOUBLE = 3'd4;
   localparam logic [2:0] KIND_SIREN  = 3'd5;

   // rotating masks, main and alternate
   localparam int MASK_W = 24;
   localparam logic [MASK_W-1:0] MASK_PULSE_MAIN = 24'h040040;
   localparam logic [MASK_W-1:0] MASK_PULSE_ALT  = 24'h001001;
   localparam logic [MASK_W-1:0] MASK_SIREN_MAIN = 24'h03F03F;
   localparam logic [MASK_W-1:0] MASK_SIREN_ALT  = 24'hFC0FC0;

   localparam int COLOR_W = 24;

   // register reset values
   localparam logic [7:0]  FADE_STEP_RESET  = 8'd6;
   localparam logic [31:0] FADE_TICKS_RESET = 32'd1344;

endpackage

// ===== hdl/lrfe_ram.sv =====
module lrfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 12
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/led_ring_effect_frame_engine.sv =====
// start item: accepted in idle, timing settles in ST_START1 and ST_START2, then the engine returns to idle
// render item: setup states ST_R1 to ST_R4, then one led per cycle while results are taken at once,
//   through the frame memory read-modify-write; a low rsp_ready stalls the led loop
// one item is worked at a time; the next is taken once the last led sits in the output register
// synchronous active-high reset clears control state and the frame store valid bits (no clearing pass)
module led_ring_effect_frame_engine #(
   parameter int NUM_LEDS  = 12,
   parameter int LEVEL_MAX = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lrfe_pkg::req_type                  req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lrfe_pkg::rsp_type                  rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lrfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lrfe_pkg::CSR_DATA_W-1:0]    csr_data
);

   import lrfe_pkg::*;

   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int CNT_W = $clog2(NUM_LEDS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START1 = 3'd1;
   localparam logic [2:0] ST_START2 = 3'd2;
   localparam logic [2:0] ST_R1     = 3'd3;
   localparam logic [2:0] ST_R2     = 3'd4;
   localparam logic [2:0] ST_R3     = 3'd5;
   localparam logic [2:0] ST_R4     = 3'd6;
   localparam logic [2:0] ST_LOOP   = 3'd7;

   // configuration registers
   logic [2:0]  kind_ff;
   logic [23:0] main_color_ff;
   logic [23:0] alt_color_ff;
   logic [31:0] duration_ff;
   logic [7:0]  fade_step_ff;
   logic [31:0] fade_ticks_ff;

   // action state
   logic [2:0]       state_ff, state_in;
   logic             op_ff;
   logic [31:0]      now_ff;
   logic [8:0]       brightness_ff, brightness_in;
   logic [IDX_W-1:0] rot_ff, rot_in;
   logic [31:0]      fade_in_end_ff, fade_in_end_in;
   logic [31:0]      fade_out_start_ff, fade_out_start_in;
   logic [31:0]      end_tick_ff, end_tick_in;
   logic             fade_en_ff, fade_en_in;

   // per-frame working registers
   logic [31:0]         t1_ff, t1_in;
   logic [31:0]         t2_ff, t2_in;
   logic                rearm_ff, rearm_in;
   logic                done_ff, done_in;
   logic                scale_en_ff, scale_en_in;
   logic                rotating_ff, rotating_in;
   logic [NUM_LEDS-1:0] mask_main_ff, mask_main_in;
   logic [NUM_LEDS-1:0] mask_alt_ff, mask_alt_in;

   // led loop
   logic [CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic                d_valid_ff, d_valid_in;
   logic [IDX_W-1:0]    d_idx_ff;
   logic                d_known_ff;
   logic [NUM_LEDS-1:0] known_ff, known_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_item_ff;

   logic        issue;
   logic        advance;
   logic [23:0] rd_data;
   logic [23:0] stored;
   logic [23:0] painted;
   logic [23:0] led_color;
   logic [15:0] prod_r, prod_g, prod_b;
   logic [7:0]  bright8;
   logic [31:0] t3;
   logic [31:0] end_minus_fade;
   logic signed [9:0] lvl_sum;
   logic [23:0] mask_main_full, mask_alt_full;
   logic        kind_rot;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_FADE;
         main_color_ff <= '0;
         alt_color_ff  <= '0;
         duration_ff   <= '0;
         fade_step_ff  <= FADE_STEP_RESET;
         fade_ticks_ff <= FADE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTION_KIND: kind_ff       <= csr_data[2:0];
            CSR_MAIN_COLOR:  main_color_ff <= csr_data[23:0];
            CSR_ALT_COLOR:   alt_color_ff  <= csr_data[23:0];
            CSR_DURATION:    duration_ff   <= csr_data;
            CSR_FADE_STEP:   fade_step_ff  <= csr_data[7:0];
            CSR_FADE_TICKS:  fade_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // loop handshake
   assign advance = d_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue   = (state_ff == ST_LOOP) && (rd_cnt_ff < CNT_W'(NUM_LEDS))
                    && (!d_valid_ff || advance);

   assign kind_rot = (kind_ff inside {KIND_PULSAR, KIND_DOUBLE, KIND_SIREN});

   // throb re-arm bound and clamp value
   assign t3             = t2_ff + fade_ticks_ff;
   assign end_minus_fade = end_tick_ff - fade_ticks_ff;

   // brightness step
   always_comb begin
      lvl_sum = $signed({1'b0, brightness_ff});
      if (now_ff > fade_out_start_ff) begin
         lvl_sum = $signed({1'b0, brightness_ff}) - $signed({2'b00, fade_step_ff});
      end else if (now_ff < fade_in_end_ff) begin
         lvl_sum = $signed({1'b0, brightness_ff}) + $signed({2'b00, fade_step_ff});
      end
   end

   // rotated masks
   always_comb begin
      if (kind_ff == KIND_SIREN) begin
         mask_main_full = MASK_SIREN_MAIN >> rot_ff;
         mask_alt_full  = MASK_SIREN_ALT >> rot_ff;
      end else begin
         mask_main_full = MASK_PULSE_MAIN >> rot_ff;
         mask_alt_full  = MASK_PULSE_ALT >> rot_ff;
      end
   end

   // sequencer and per-frame setup
   always_comb begin
      state_in          = state_ff;
      brightness_in     = brightness_ff;
      rot_in            = rot_ff;
      fade_in_end_in    = fade_in_end_ff;
      fade_out_start_in = fade_out_start_ff;
      end_tick_in       = end_tick_ff;
      fade_en_in        = fade_en_ff;
      t1_in             = t1_ff;
      t2_in             = t2_ff;
      rearm_in          = rearm_ff;
      done_in           = done_ff;
      scale_en_in       = scale_en_ff;
      rotating_in       = rotating_ff;
      mask_main_in      = mask_main_ff;
      mask_alt_in       = mask_alt_ff;
      rd_cnt_in         = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_item.opcode == OP_START) ? ST_START1 : ST_R1;
            end
         end
         // start: clear brightness and rotation, set end tick, fade-in end and enable
         ST_START1: begin
            brightness_in = '0;
            rot_in        = '0;
            end_tick_in   = now_ff + duration_ff;
            fade_en_in    = !(fade_ticks_ff > (duration_ff >> 1));
            if (!(fade_ticks_ff > (duration_ff >> 1))) begin
               fade_in_end_in = now_ff + fade_ticks_ff;
            end
            state_in = ST_START2;
         end
         // start: fade-out start
         ST_START2: begin
            if (fade_en_ff) begin
               fade_out_start_in = (kind_ff == KIND_THROB) ? fade_in_end_ff : end_minus_fade;
            end
            state_in = ST_IDLE;
         end
         ST_R1: begin
            t1_in    = fade_out_start_ff + fade_ticks_ff;
            done_in  = end_tick_ff < now_ff;
            state_in = ST_R2;
         end
         ST_R2: begin
            rearm_in = (kind_ff == KIND_THROB) && (now_ff > t1_ff);
            t2_in    = t1_ff + fade_ticks_ff;
            state_in = ST_R3;
         end
         // throb window re-arm
         ST_R3: begin
            if (rearm_ff) begin
               if (t3 > end_tick_ff) begin
                  fade_in_end_in    = end_minus_fade;
                  fade_out_start_in = end_minus_fade;
               end else begin
                  fade_in_end_in    = t2_ff;
                  fade_out_start_in = t2_ff;
               end
            end
            state_in = ST_R4;
         end
         // envelope and paint masks
         ST_R4: begin
            scale_en_in = fade_en_ff
                          && !(now_ff > fade_in_end_ff && now_ff < fade_out_start_ff);
            if (fade_en_ff && !(now_ff > fade_in_end_ff && now_ff < fade_out_start_ff)) begin
               if (lvl_sum < 10'sd0) begin
                  brightness_in = '0;
               end else if (lvl_sum > $signed(10'(LEVEL_MAX))) begin
                  brightness_in = 9'(LEVEL_MAX);
               end else begin
                  brightness_in = lvl_sum[8:0];
               end
            end
            rotating_in  = kind_rot;
            mask_main_in = mask_main_full[NUM_LEDS-1:0];
            mask_alt_in  = mask_alt_full[NUM_LEDS-1:0];
            if (kind_rot) begin
               rot_in = (rot_ff == IDX_W'(NUM_LEDS - 1)) ? '0 : rot_ff + 1'b1;
            end
            rd_cnt_in = '0;
            state_in  = ST_LOOP;
         end
         ST_LOOP: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (advance && d_idx_ff == IDX_W'(NUM_LEDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // frame memory
   lrfe_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(NUM_LEDS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (d_idx_ff),
      .wr_data (led_color),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // paint and scale one led
   assign stored = d_known_ff ? rd_data : '0;
   always_comb begin
      painted = stored;
      if (!rotating_ff) begin
         painted = main_color_ff;
      end else if (mask_main_ff[d_idx_ff]) begin
         painted = main_color_ff;
      end else if (mask_alt_ff[d_idx_ff]) begin
         painted = (kind_ff == KIND_PULSAR) ? '0 : alt_color_ff;
      end
   end

   assign bright8 = brightness_ff[7:0];
   assign prod_r  = bright8 * painted[23:16];
   assign prod_g  = bright8 * painted[15:8];
   assign prod_b  = bright8 * painted[7:0];
   assign led_color = scale_en_ff ? {prod_r[15:8], prod_g[15:8], prod_b[15:8]} : painted;

   // loop control and output register next values
   always_comb begin
      d_valid_in   = d_valid_ff;
      known_in     = known_ff;
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         d_valid_in = 1'b1;
      end else if (advance) begin
         d_valid_in = 1'b0;
      end
      if (advance) begin
         known_in[d_idx_ff] = 1'b1;
         rsp_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         brightness_ff     <= '0;
         rot_ff            <= '0;
         fade_in_end_ff    <= '0;
         fade_out_start_ff <= '0;
         end_tick_ff       <= '0;
         fade_en_ff        <= 1'b0;
         rd_cnt_ff         <= '0;
         d_valid_ff        <= 1'b0;
         known_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         brightness_ff     <= brightness_in;
         rot_ff            <= rot_in;
         fade_in_end_ff    <= fade_in_end_in;
         fade_out_start_ff <= fade_out_start_in;
         end_tick_ff       <= end_tick_in;
         fade_en_ff        <= fade_en_in;
         rd_cnt_ff         <= rd_cnt_in;
         d_valid_ff        <= d_valid_in;
         known_ff          <= known_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_item.opcode;
         now_ff <= req_item.now_ticks;
      end
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      rearm_ff     <= rearm_in;
      done_ff      <= done_in;
      scale_en_ff  <= scale_en_in;
      rotating_ff  <= rotating_in;
      mask_main_ff <= mask_main_in;
      mask_alt_ff  <= mask_alt_in;
      if (issue) begin
         d_idx_ff   <= rd_cnt_ff[IDX_W-1:0];
         d_known_ff <= known_ff[rd_cnt_ff[IDX_W-1:0]];
      end
      if (advance) begin
         rsp_item_ff.led_index <= 4'(d_idx_ff);
         rsp_item_ff.red       <= led_color[23:16];
         rsp_item_ff.green     <= led_color[15:8];
         rsp_item_ff.blue      <= led_color[7:0];
         rsp_item_ff.last      <= (d_idx_ff == IDX_W'(NUM_LEDS - 1));
         rsp_item_ff.finished  <= done_ff && (op_ff == OP_RENDER);
      end
   end

endmodule

// ===== hdl/lrfe_checker.sv =====
module lrfe_checker #(
   parameter int NUM_LEDS = 12
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lrfe_pkg::rsp_type rsp_item
);

   import lrfe_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed");

   // the last flag marks the final led of the ring
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> rsp_item.led_index == 4'(NUM_LEDS - 1))
      else $error("last flag on wrong led");

   // no new item is taken while a frame is still being emitted
   a_busy_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> !req_ready)
      else $error("input taken in the middle of a frame");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   // every result item carries a led index within the ring
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.led_index <= 4'(NUM_LEDS - 1))
      else $error("led index out of range");

endmodule

bind led_ring_effect_frame_engine lrfe_checker #(.NUM_LEDS(NUM_LEDS)) u_lrfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
